// ===== design/pas_pkg.sv =====
`timescale 1ns / 1ps
package pas_pkg;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_STOP   = 2'd1,
    OP_SETUP  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE_DROP     = 4'd0,
    ST_INVALID       = 4'd1,
    ST_WRONG_SOURCE  = 4'd2,
    ST_VERSION_ERROR = 4'd3,
    ST_ARMING        = 4'd4,
    ST_START_PASSED  = 4'd5,
    ST_LATE          = 4'd6,
    ST_ACCEPTED      = 4'd7,
    ST_COMMAND_DONE  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    MODE_PENDING = 3'b001,
    MODE_RUNNING = 3'b010,
    MODE_IDLE    = 3'b100
  } mode_t;

  localparam logic [1:0] MODE_CODE_PENDING = 2'd0;
  localparam logic [1:0] MODE_CODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_CODE_IDLE    = 2'd2;

  typedef enum logic [2:0] {
    REG_BEAM_SOURCE       = 3'd0,
    REG_BEAM_POLARIZATION = 3'd1,
    REG_EXPECTED_VERSION  = 3'd2,
    REG_START_SECONDS     = 3'd3,
    REG_START_NEVER       = 3'd4
  } reg_idx_t;

  localparam int unsigned AddrWidth = 5;

  typedef struct packed {
    logic [1:0]  operation;
    logic        hdr_valid;
    logic [15:0] packet_source;
    logic [7:0]  packet_polarization;
    logic [7:0]  packet_version;
    logic [31:0] time_seconds;
    logic [31:0] packet_sequence;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        start_flag;
    logic [30:0] missing_packets;
    logic [1:0]  mode_now;
  } result_t;

  typedef struct packed {
    mode_t       run_mode;
    logic        armed_flag;
    logic [31:0] expected_sequence;
  } state_t;

  typedef struct packed {
    logic [15:0] beam_source;
    logic [7:0]  beam_polarization;
    logic [7:0]  expected_version;
    logic [31:0] start_seconds;
    logic        start_never;
  } cfg_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] code;
    case (m)
      MODE_PENDING: code = MODE_CODE_PENDING;
      MODE_RUNNING: code = MODE_CODE_RUNNING;
      MODE_IDLE:    code = MODE_CODE_IDLE;
      default:      code = MODE_CODE_PENDING;
    endcase
    return code;
  endfunction

endpackage

// ===== design/pas_if.sv =====
`timescale 1ns / 1ps
interface pas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        hdr_valid;
  logic [15:0] packet_source;
  logic [7:0]  packet_polarization;
  logic [7:0]  packet_version;
  logic [31:0] time_seconds;
  logic [31:0] packet_sequence;

  modport source (
    output valid, operation, hdr_valid, packet_source, packet_polarization,
           packet_version, time_seconds, packet_sequence,
    input  ready
  );
  modport sink (
    input  valid, operation, hdr_valid, packet_source, packet_polarization,
           packet_version, time_seconds, packet_sequence,
    output ready
  );
endinterface

interface pas_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        start_flag;
  logic [30:0] missing_packets;
  logic [1:0]  mode_now;

  modport source (
    output valid, status, start_flag, missing_packets, mode_now,
    input  ready
  );
  modport sink (
    input  valid, status, start_flag, missing_packets, mode_now,
    output ready
  );
endinterface

// ===== design/pas_decide.sv =====
`timescale 1ns / 1ps
module pas_decide (
  input  pas_pkg::item_t   item,
  input  pas_pkg::state_t  state,
  input  pas_pkg::cfg_t    cfg,
  output pas_pkg::state_t  state_nxt,
  output pas_pkg::result_t result
);

  pas_pkg::status_t status;
  logic             start;
  logic             go;
  logic [31:0]      base;
  logic [31:0]      diff;

  always_comb begin
    state_nxt = state;
    status    = pas_pkg::ST_COMMAND_DONE;
    start     = 1'b0;
    go        = 1'b0;
    base      = state.expected_sequence;
    diff      = '0;
    case (pas_pkg::op_t'(item.operation))
      pas_pkg::OP_STOP: begin
        state_nxt.run_mode = pas_pkg::MODE_IDLE;
      end
      pas_pkg::OP_SETUP: begin
        if (cfg.start_never) begin
          state_nxt.run_mode = pas_pkg::MODE_IDLE;
        end
      end
      pas_pkg::OP_PACKET: begin
        if (state.run_mode == pas_pkg::MODE_IDLE) begin
          status = pas_pkg::ST_IDLE_DROP;
        end else if (!item.hdr_valid) begin
          state_nxt.armed_flag        = 1'b0;
          state_nxt.expected_sequence = '0;
          status = pas_pkg::ST_INVALID;
        end else if (item.packet_source != cfg.beam_source ||
                     item.packet_polarization != cfg.beam_polarization) begin
          status = pas_pkg::ST_WRONG_SOURCE;
        end else if (state.run_mode == pas_pkg::MODE_PENDING) begin
          if (item.packet_version != cfg.expected_version) begin
            state_nxt.run_mode = pas_pkg::MODE_IDLE;
            status = pas_pkg::ST_VERSION_ERROR;
          end else if (!state.armed_flag || item.time_seconds < cfg.start_seconds) begin
            state_nxt.armed_flag = 1'b1;
            if (cfg.start_seconds != '0 && item.time_seconds >= cfg.start_seconds) begin
              status = pas_pkg::ST_START_PASSED;
            end else begin
              status = pas_pkg::ST_ARMING;
            end
          end else begin
            base                 = item.packet_sequence;
            state_nxt.run_mode   = pas_pkg::MODE_RUNNING;
            state_nxt.armed_flag = 1'b0;
            start                = 1'b1;
            go                   = 1'b1;
          end
        end else begin
          go = 1'b1;
        end
        if (go) begin
          diff = item.packet_sequence - base;
          if (diff[31]) begin
            status = pas_pkg::ST_LATE;
            start  = 1'b0;
            diff   = '0;
          end else begin
            state_nxt.expected_sequence = item.packet_sequence + 32'd1;
            status = pas_pkg::ST_ACCEPTED;
          end
        end
      end
      default: begin
      end
    endcase
    result.status          = status;
    result.start_flag      = start;
    result.missing_packets = diff[30:0];
    result.mode_now        = pas_pkg::mode_code(state_nxt.run_mode);
  end

endmodule

// ===== design/packet_admission_sequencer.sv =====
// pipeline: an accepted item passes the input register, then the state and result register,
// before its result is offered on the result channel
// throughput: one item per cycle, limited only by the result channel back-pressure
// reset: synchronous active-low rst_n clears both stage valids, mode to pending,
// armed flag and expected sequence to zero, and all configuration registers to zero
`timescale 1ns / 1ps
module packet_admission_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  pas_in_if.sink                        in_ch,
  pas_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pas_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  pas_pkg::cfg_t    cfg_r;
  pas_pkg::state_t  state_r;
  pas_pkg::state_t  state_nxt;
  pas_pkg::item_t   item_r;
  pas_pkg::result_t result_nxt;
  pas_pkg::result_t result_r;
  logic             item_valid_r;
  logic             out_valid_r;
  logic             advance;
  logic             in_take;
  logic             cfg_write;
  pas_pkg::reg_idx_t cfg_idx;

  assign advance   = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;
  assign in_take   = in_ch.valid && in_ch.ready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = pas_pkg::reg_idx_t'(paddr[pas_pkg::AddrWidth-1:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      pas_pkg::REG_BEAM_SOURCE:       prdata = {16'd0, cfg_r.beam_source};
      pas_pkg::REG_BEAM_POLARIZATION: prdata = {24'd0, cfg_r.beam_polarization};
      pas_pkg::REG_EXPECTED_VERSION:  prdata = {24'd0, cfg_r.expected_version};
      pas_pkg::REG_START_SECONDS:     prdata = cfg_r.start_seconds;
      pas_pkg::REG_START_NEVER:       prdata = {31'd0, cfg_r.start_never};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        pas_pkg::REG_BEAM_SOURCE:       cfg_r.beam_source       <= pwdata[15:0];
        pas_pkg::REG_BEAM_POLARIZATION: cfg_r.beam_polarization <= pwdata[7:0];
        pas_pkg::REG_EXPECTED_VERSION:  cfg_r.expected_version  <= pwdata[7:0];
        pas_pkg::REG_START_SECONDS:     cfg_r.start_seconds     <= pwdata;
        pas_pkg::REG_START_NEVER:       cfg_r.start_never       <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  pas_decide u_decide (
    .item      (item_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.operation           <= in_ch.operation;
      item_r.hdr_valid           <= in_ch.hdr_valid;
      item_r.packet_source       <= in_ch.packet_source;
      item_r.packet_polarization <= in_ch.packet_polarization;
      item_r.packet_version      <= in_ch.packet_version;
      item_r.time_seconds        <= in_ch.time_seconds;
      item_r.packet_sequence     <= in_ch.packet_sequence;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.run_mode          <= pas_pkg::MODE_PENDING;
      state_r.armed_flag        <= 1'b0;
      state_r.expected_sequence <= '0;
      out_valid_r               <= 1'b0;
    end else begin
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = result_r.status;
  assign out_ch.start_flag      = result_r.start_flag;
  assign out_ch.missing_packets = result_r.missing_packets;
  assign out_ch.mode_now        = result_r.mode_now;

endmodule
